[hdl/chacha20_key_erasure_drbg_defines.svh]
// Assertion macros used by the generator top level
`ifndef CHACHA20_KEY_ERASURE_DRBG_DEFINES_SVH
`define CHACHA20_KEY_ERASURE_DRBG_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle
`define ASSERT_IMPL(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/ckd_pkg.sv]
// Types, constants and helpers for the ChaCha20 key erasure generator
package ckd_pkg;
  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int TICK_PERIOD_LOG2_DEF = 6;
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam logic [1:0] CMD_MIX = 2'd0;
  localparam logic [1:0] CMD_SEED = 2'd1;
  localparam logic [1:0] CMD_GEN = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] entropy_value;
    logic [63:0] extra_value;
    logic        extra_valid;
    logic [6:0]  byte_count;
  } req_t;

  typedef struct packed {
    logic [63:0] random_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    logic        not_seeded;
  } rsp_t;

  typedef logic [15:0][31:0] cstate_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] quarter(input logic [127:0] q);
    logic [31:0] a, b, c, d;
    begin
      a = q[31:0]; b = q[63:32]; c = q[95:64]; d = q[127:96];
      a = a + b; d = rotl(d ^ a, 16);
      c = c + d; b = rotl(b ^ c, 12);
      a = a + b; d = rotl(d ^ a, 8);
      c = c + d; b = rotl(b ^ c, 7);
      quarter = {d, c, b, a};
    end
  endfunction
endpackage

[hdl/ckd_round.sv]
// ChaCha double round unit, one double round per cycle when enabled
module ckd_round
  import ckd_pkg::*;
(
  input  logic    clk,
  input  logic    load,
  input  logic    step,
  input  cstate_t init,
  output cstate_t x
);
  cstate_t c, d;
  logic [127:0] q;

  // Column rounds then diagonal rounds
  always_comb begin
    c = x;
    for (int i = 0; i < 4; i++) begin
      q = quarter({c[12+i], c[8+i], c[4+i], c[i]});
      {c[12+i], c[8+i], c[4+i], c[i]} = q;
    end
    d = c;
    for (int i = 0; i < 4; i++) begin
      q = quarter({d[12+((i+3)%4)], d[8+((i+2)%4)], d[4+((i+1)%4)], d[i]});
      {d[12+((i+3)%4)], d[8+((i+2)%4)], d[4+((i+1)%4)], d[i]} = q;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x <= init;
    end else if (step) begin
      x <= d;
    end
  end
endmodule

[hdl/chacha20_key_erasure_drbg.sv]
// Top level of the ChaCha20 key erasure random generator
// Generate: key block, then output block, then the output words, each held while the output stalls.
// Mix: one pool word per cycle through the shared mix step; a tick that wraps mixes, then rekeys.
// Seed and ignored commands finish on acceptance. Not ready while a request is in work or a result is not yet taken.
// Throughput is set by the single double-round unit and the one-word pool mixer.
// Synchronous reset clears pool, key, counter, nonce, seeded flag and tick count.
`include "chacha20_key_erasure_drbg_defines.svh"
module chacha20_key_erasure_drbg
  import ckd_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF,
  parameter int TICK_PERIOD_LOG2 = TICK_PERIOD_LOG2_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);
  localparam logic [2:0] S_IDLE = 3'd0, S_MIX = 3'd1, S_KBLK = 3'd2,
                         S_OBLK = 3'd3, S_OUT = 3'd4;
  localparam int TW = (TICK_PERIOD_LOG2 > 0) ? TICK_PERIOD_LOG2 : 1;

  logic [2:0] state;
  logic [7:0][31:0] pool, key;
  logic [63:0] ctr, nonce;
  logic [63:0] bctr;
  logic seeded;
  logic [TW-1:0] tick;
  logic [3:0] rcnt;
  logic [2:0] idx;
  logic [31:0] lo, hi;
  logic [63:0] extra;
  logic extra_pend, tick_xor;
  logic [6:0] left;
  cstate_t init, rx, fin;
  cstate_t oblk;
  logic load, step;

  assign in_stall = (state != S_IDLE) || out_valid;
  wire acc = in_valid && !in_stall;

  // Load the output block with the next counter at the end of the key block
  assign bctr = (state == S_KBLK) ? ctr + 64'd1 : ctr;

  always_comb begin
    init = {nonce[63:32], nonce[31:0], bctr[63:32], bctr[31:0],
            key[7], key[6], key[5], key[4], key[3], key[2], key[1], key[0],
            SIGMA3, SIGMA2, SIGMA1, SIGMA0};
    for (int i = 0; i < 16; i++) fin[i] = rx[i] + init[i];
  end
  assign load = (state == S_IDLE && acc) || (state == S_KBLK && rcnt == 4'(DOUBLE_ROUNDS));
  assign step = (state == S_KBLK || state == S_OBLK) && rcnt < 4'(DOUBLE_ROUNDS);

  ckd_round u_round (.clk(clk), .load(load), .step(step), .init(init), .x(rx));

  // Pool mix step on the current word
  logic [31:0] pw;
  assign pw = rotl(pool[idx] ^ lo, 13) + hi;

  wire [TW-1:0] tick_nx = (TICK_PERIOD_LOG2 > 0) ? tick + TW'(1) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; pool <= '0; key <= '0; ctr <= '0; nonce <= '0;
      seeded <= 1'b0; tick <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (acc) begin
          idx <= '0; rcnt <= '0;
          lo <= in_data.entropy_value[31:0]; hi <= in_data.entropy_value[63:32];
          extra <= in_data.extra_value;
          left <= (in_data.byte_count > 7'd64) ? 7'd64 : in_data.byte_count;
          case (in_data.command)
            CMD_MIX: begin
              extra_pend <= 1'b0; tick_xor <= 1'b0; state <= S_MIX;
            end
            CMD_SEED: begin
              key <= pool; ctr <= '0; nonce <= in_data.entropy_value; seeded <= 1'b1;
            end
            CMD_TICK: if (seeded) begin
              tick <= tick_nx;
              if (tick_nx == '0) begin
                extra_pend <= in_data.extra_valid; tick_xor <= 1'b1; state <= S_MIX;
              end
            end
            default: if (!seeded) begin
              out_data <= '{random_word: '0, valid_bytes: '0, last_word: 1'b1,
                            not_seeded: 1'b1};
              out_valid <= 1'b1;
            end else if (in_data.byte_count != '0) begin
              state <= S_KBLK;
            end
          endcase
        end
        S_MIX: begin
          pool[idx] <= pw;
          idx <= idx + 3'd1;
          // Restart with the extra value after the last word, else chain the halves
          if (idx == 3'd7 && extra_pend) begin
            extra_pend <= 1'b0;
            lo <= extra[31:0]; hi <= extra[63:32];
          end else begin
            lo <= lo ^ pool[idx + 3'd3];
            hi <= hi ^ pool[idx + 3'd5];
          end
          if (idx == 3'd7 && !extra_pend) begin
            state <= S_IDLE;
            if (tick_xor) for (int i = 0; i < 8; i++)
              key[i] <= key[i] ^ ((i == 7) ? pw : pool[i]);
          end
        end
        S_KBLK: begin
          // Hold the new key in the low half of oblk until the output block is done
          if (rcnt == 4'(DOUBLE_ROUNDS)) begin
            for (int i = 0; i < 8; i++) oblk[i] <= fin[i];
            ctr <= ctr + 64'd1; rcnt <= '0; state <= S_OBLK;
          end else rcnt <= rcnt + 4'd1;
        end
        S_OBLK: begin
          if (rcnt == 4'(DOUBLE_ROUNDS)) begin
            key <= oblk[7:0];
            oblk <= fin; ctr <= ctr + 64'd1; idx <= '0; state <= S_OUT;
          end else rcnt <= rcnt + 4'd1;
        end
        S_OUT: if (!out_valid || !out_stall) begin
          out_data <= '{random_word: {oblk[{idx, 1'b1}], oblk[{idx, 1'b0}]},
                        valid_bytes: (left > 7'd8) ? 4'd8 : left[3:0],
                        last_word: left <= 7'd8, not_seeded: 1'b0};
          out_valid <= 1'b1;
          left <= left - 7'd8; idx <= idx + 3'd1;
          if (left <= 7'd8) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_busy_stall, clk, rst, state != S_IDLE, in_stall)
  `ASSERT_IMPL(a_ns_last, clk, rst, out_valid && out_data.not_seeded, out_data.last_word)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
endmodule

[dv/tb_chacha20_key_erasure_drbg.sv]
// Testbench for the ChaCha20 key erasure random generator: self-predicting request/result checker
`timescale 1ns / 1ps
module tb_chacha20_key_erasure_drbg;
  import ckd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 64;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  chacha20_key_erasure_drbg uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state
  logic [31:0] pool_q [8];
  logic [31:0] key_q [8];
  logic [63:0] ctr_q;
  logic [63:0] nonce_q;
  logic        seeded_q;
  logic [5:0]  ticks_q;

  rsp_t expected_words[$];
  int   error_count;
  int   result_count;
  int   request_count;
  int   idle_cycles;
  bit   sender_gaps;
  bit   receiver_gaps;
  int   hold_off;

  function automatic logic [31:0] rot32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void qround(ref logic [31:0] x[16], input int a, int b, int c, int d);
    x[a] += x[b]; x[d] = rot32(x[d] ^ x[a], 16);
    x[c] += x[d]; x[b] = rot32(x[b] ^ x[c], 12);
    x[a] += x[b]; x[d] = rot32(x[d] ^ x[a], 8);
    x[c] += x[d]; x[b] = rot32(x[b] ^ x[c], 7);
  endfunction

  function automatic void chacha_block(output logic [31:0] blk[16], input logic [63:0] ctr);
    logic [31:0] init[16];
    init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
    for (int i = 0; i < 8; i++) init[4 + i] = key_q[i];
    init[12] = ctr[31:0];     init[13] = ctr[63:32];
    init[14] = nonce_q[31:0]; init[15] = nonce_q[63:32];
    blk = init;
    for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++) begin
      qround(blk, 0, 4, 8, 12);  qround(blk, 1, 5, 9, 13);
      qround(blk, 2, 6, 10, 14); qround(blk, 3, 7, 11, 15);
      qround(blk, 0, 5, 10, 15); qround(blk, 1, 6, 11, 12);
      qround(blk, 2, 7, 8, 13);  qround(blk, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) blk[i] += init[i];
  endfunction

  function automatic void stir_pool(logic [63:0] v);
    logic [31:0] lo, hi;
    lo = v[31:0];
    hi = v[63:32];
    for (int i = 0; i < 8; i++) begin
      pool_q[i] = rot32(pool_q[i] ^ lo, 13) + hi;
      lo ^= pool_q[(i + 3) & 7];
      hi ^= pool_q[(i + 5) & 7];
    end
  endfunction

  function automatic void clear_generator();
    for (int i = 0; i < 8; i++) begin
      pool_q[i] = '0;
      key_q[i] = '0;
    end
    ctr_q = '0;
    nonce_q = '0;
    seeded_q = 1'b0;
    ticks_q = '0;
  endfunction

  // Apply one accepted request to the predictor and queue its words
  function automatic void predict_request(req_t r);
    logic [31:0] kblk[16], oblk[16];
    int n, words, left;
    rsp_t w;
    case (r.command)
      CMD_MIX: stir_pool(r.entropy_value);
      CMD_SEED: begin
        for (int i = 0; i < 8; i++) key_q[i] = pool_q[i];
        ctr_q = '0;
        nonce_q = r.entropy_value;
        seeded_q = 1'b1;
      end
      CMD_TICK: begin
        if (seeded_q) begin
          ticks_q = ticks_q + 6'd1;
          if (ticks_q == 6'd0) begin
            stir_pool(r.entropy_value);
            if (r.extra_valid) stir_pool(r.extra_value);
            for (int i = 0; i < 8; i++) key_q[i] ^= pool_q[i];
          end
        end
      end
      default: begin
        if (!seeded_q) begin
          w = '0;
          w.last_word = 1'b1;
          w.not_seeded = 1'b1;
          expected_words.push_back(w);
        end else if (r.byte_count != 0) begin
          n = (r.byte_count > 64) ? 64 : int'(r.byte_count);
          words = (n + 7) / 8;
          chacha_block(kblk, ctr_q);
          ctr_q++;
          chacha_block(oblk, ctr_q);
          ctr_q++;
          for (int i = 0; i < 8; i++) key_q[i] = kblk[i];
          for (int i = 0; i < words; i++) begin
            left = n - 8 * i;
            w.random_word = {oblk[2 * i + 1], oblk[2 * i]};
            w.valid_bytes = (left > 8) ? 4'd8 : 4'(left);
            w.last_word = (i == words - 1);
            w.not_seeded = 1'b0;
            expected_words.push_back(w);
          end
        end
      end
    endcase
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver stall: random bursts, or a long counted hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19) - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    rsp_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_data.random_word !== exp_w.random_word) begin
          $display("%0t: random_word expected %h actual %h", $time,
                   exp_w.random_word, out_data.random_word);
          error_count++;
        end
        if (out_data.valid_bytes !== exp_w.valid_bytes) begin
          $display("%0t: valid_bytes expected %0d actual %0d", $time,
                   exp_w.valid_bytes, out_data.valid_bytes);
          error_count++;
        end
        if (out_data.last_word !== exp_w.last_word) begin
          $display("%0t: last_word expected %b actual %b", $time,
                   exp_w.last_word, out_data.last_word);
          error_count++;
        end
        if (out_data.not_seeded !== exp_w.not_seeded) begin
          $display("%0t: not_seeded expected %b actual %b", $time,
                   exp_w.not_seeded, out_data.not_seeded);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expected_words.size());
        $display("tb_chacha20_key_erasure_drbg: FAIL");
        $finish;
      end
    end
  end

  // Offer one request and hold it until accepted; the caller or the next gap drops valid
  task automatic send_request(req_t r);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    predict_request(r);
    request_count++;
  endtask

  function automatic req_t make_request(logic [1:0] cmd, logic [63:0] v, logic [6:0] n);
    req_t r;
    r.command = cmd;
    r.entropy_value = v;
    r.extra_value = {$urandom, $urandom};
    r.extra_valid = 1'($urandom_range(0, 1));
    r.byte_count = n;
    return r;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Generate and tick before seeding, zero and saturated sizes, field extremes
  task automatic test_directed();
    send_request(make_request(CMD_GEN, '0, 7'd16));
    send_request(make_request(CMD_TICK, '1, 7'd0));
    send_request(make_request(CMD_MIX, '0, 7'd0));
    send_request(make_request(CMD_MIX, '1, 7'd127));
    send_request(make_request(CMD_SEED, 64'h0123456789abcdef, 7'd0));
    send_request(make_request(CMD_GEN, '1, 7'd0));
    send_request(make_request(CMD_GEN, '0, 7'd1));
    send_request(make_request(CMD_GEN, '0, 7'd8));
    send_request(make_request(CMD_GEN, '0, 7'd9));
    send_request(make_request(CMD_GEN, '0, 7'd64));
    send_request(make_request(CMD_GEN, '0, 7'd65));
    send_request(make_request(CMD_GEN, '1, 7'd127));
    send_request(make_request(CMD_MIX, 64'hdeadbeefcafef00d, 7'd3));
    send_request(make_request(CMD_SEED, '1, 7'd0));
    send_request(make_request(CMD_GEN, '0, 7'd33));
  endtask

  // Run a full tick period twice so the periodic rekey happens, with and without extra
  task automatic test_tick_rekey();
    req_t r;
    for (int p = 0; p < 2; p++) begin
      for (int i = 0; i < 64; i++) begin
        r = make_request(CMD_TICK, {$urandom, $urandom}, 7'($urandom));
        if (i == 63) r.extra_valid = p[0];
        send_request(r);
      end
      send_request(make_request(CMD_GEN, '0, 7'd64));
    end
  endtask

  // Mostly generates with random sizes, mixed with seeds, mixes and ticks
  task automatic test_random(int count);
    int pick;
    logic [6:0] n;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      n = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
      if (pick < 6)
        send_request(make_request(CMD_GEN, {$urandom, $urandom}, n));
      else if (pick == 6)
        send_request(make_request(CMD_SEED, {$urandom, $urandom}, n));
      else if (pick == 7)
        send_request(make_request(CMD_MIX, {$urandom, $urandom}, n));
      else
        send_request(make_request(CMD_TICK, {$urandom, $urandom}, n));
    end
  endtask

  // Stall the output for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 8; i++)
      send_request(make_request(CMD_GEN, '0, 7'd64));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    error_count = 0;
    result_count = 0;
    request_count = 0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    hold_off = 0;
    clear_generator();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_tick_rekey();
    test_random(6);
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_random(8);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d result words: unseeded, zero and saturated sizes,",
             request_count, result_count);
    $display("reseeds, periodic tick rekey, and a long output stall.");
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("tb_chacha20_key_erasure_drbg: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, expected_words.size());
      $display("tb_chacha20_key_erasure_drbg: FAIL");
    end
    $finish;
  end
endmodule
